// ----- rtl/selcs_pkg.sv -----
// Shared types, constants and helper functions for the screen-edge LED colour sampler.
// No dependencies; every other file of the block imports this package.
package selcs_pkg;

    localparam int LED_COUNT_DEF  = 25;
    localparam int COORD_BITS_DEF = 12;

    localparam int DIM_BITS      = 12;
    localparam int SAMPLE_BITS   = 8;
    localparam int GAIN_BITS     = 9;
    localparam int CHAN_BITS     = 8;
    localparam int IDX_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int PERIM_BITS    = DIM_BITS + 2;

    localparam logic [DIM_BITS-1:0]    WIDTH_RST  = DIM_BITS'(1920);
    localparam logic [DIM_BITS-1:0]    HEIGHT_RST = DIM_BITS'(1080);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_RST = SAMPLE_BITS'(50);
    localparam logic [GAIN_BITS-1:0]   BRIGHT_RST = GAIN_BITS'(102);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_SAMPLE,
        CFG_BRIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_BITS-1:0]    width;
        logic [DIM_BITS-1:0]    height;
        logic [SAMPLE_BITS-1:0] sample;
        logic [GAIN_BITS-1:0]   bright;
    } t_cfg;

    typedef enum logic [1:0] {
        FS_CLOSED,
        FS_SETUP,
        FS_OPEN
    } t_frame_state;

    typedef logic [CHAN_BITS-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    // Signed width that holds every corner, window end and pixel coordinate.
    function automatic int corner_bits(input int coord_bits);
        return ((coord_bits > DIM_BITS) ? coord_bits : DIM_BITS) + 3;
    endfunction

    // Channel times gain / 256, truncated and saturated at full scale.
    function automatic t_chan scale_channel(input t_chan v, input logic [GAIN_BITS-1:0] gain);
        logic [CHAN_BITS+GAIN_BITS-1:0] prod;
        logic [GAIN_BITS-1:0]           scaled;
        prod   = (CHAN_BITS+GAIN_BITS)'(v) * (CHAN_BITS+GAIN_BITS)'(gain);
        scaled = prod[CHAN_BITS+GAIN_BITS-1:CHAN_BITS];
        if (|scaled[GAIN_BITS-1:CHAN_BITS]) begin
            return '1;
        end
        return scaled[CHAN_BITS-1:0];
    endfunction

endpackage

// ----- rtl/selcs_if.sv -----
// Handshake interfaces of the colour sampler: pixel stream, LED result stream and register writes.
// Depends on selcs_pkg for field widths.
interface selcs_pixel_if import selcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] pixel_red;
    logic [CHAN_BITS-1:0] pixel_green;
    logic [CHAN_BITS-1:0] pixel_blue;
    logic                 frame_end;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_end, input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_end, output ready);
endinterface

interface selcs_led_if import selcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_BITS-1:0]  led_index;
    logic [CHAN_BITS-1:0] led_red;
    logic [CHAN_BITS-1:0] led_green;
    logic [CHAN_BITS-1:0] led_blue;
    logic                 last_led;

    modport source (output valid, led_index, led_red, led_green, led_blue, last_led, input ready);
    modport sink   (input valid, led_index, led_red, led_green, led_blue, last_led, output ready);
endinterface

interface selcs_cfg_if import selcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/selcs_cfg_regs.sv -----
// Configuration register file: image size, window edge and output gain.
// Depends on selcs_pkg and selcs_cfg_if.
module selcs_cfg_regs import selcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    selcs_cfg_if.sink   i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WIDTH:  n_cfg.width  = i_cfg.data[DIM_BITS-1:0];
                CFG_HEIGHT: n_cfg.height = i_cfg.data[DIM_BITS-1:0];
                CFG_SAMPLE: n_cfg.sample = i_cfg.data[SAMPLE_BITS-1:0];
                CFG_BRIGHT: n_cfg.bright = i_cfg.data[GAIN_BITS-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_cfg.sample <= SAMPLE_RST;
            r_cfg.bright <= BRIGHT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/selcs_placer.sv -----
// Frame setup: latches the image size, divides the perimeter into LED spacings and places
// every sample window along the edges. Four register stages; depends on selcs_pkg.
module selcs_placer import selcs_pkg::*; #(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  t_cfg                                       i_cfg,
    input  logic                                       i_start,
    output logic                                       o_done,
    output logic [DIM_BITS-1:0]                        o_lat_w,
    output logic [DIM_BITS-1:0]                        o_lat_h,
    output logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] o_row_lo,
    output logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] o_row_end,
    output logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] o_col_lo,
    output logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] o_col_end
);

    localparam int CW        = corner_bits(COORD_BITS);
    localparam int DIVISOR   = LED_COUNT + 1;
    localparam int SHIFT     = PERIM_BITS + $clog2(DIVISOR);
    localparam int PROD_BITS = PERIM_BITS + SHIFT;
    localparam longint unsigned RECIP_FULL = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'(RECIP_FULL);

    logic [3:0]                  r_stage;
    logic [DIM_BITS-1:0]         r_w;
    logic [DIM_BITS-1:0]         r_h;
    logic [SAMPLE_BITS-1:0]      r_s;
    logic [PROD_BITS-1:0]        r_prod;
    logic [PERIM_BITS-1:0]       r_spacing;
    logic [PERIM_BITS-1:0]       r_j [LED_COUNT];
    logic [LED_COUNT-1:0][CW-1:0] r_row_lo;
    logic [LED_COUNT-1:0][CW-1:0] r_row_end;
    logic [LED_COUNT-1:0][CW-1:0] r_col_lo;
    logic [LED_COUNT-1:0][CW-1:0] r_col_end;

    logic [PERIM_BITS-1:0]        perim;
    logic signed [CW-1:0]         w_s;
    logic signed [CW-1:0]         h_s;
    logic signed [CW-1:0]         s_s;
    logic signed [CW-1:0]         right_s;
    logic signed [CW-1:0]         bottom_s;
    logic signed [CW-1:0]         around_s;
    logic signed [CW-1:0]         j_s [LED_COUNT];
    logic signed [CW-1:0]         c_row [LED_COUNT];
    logic signed [CW-1:0]         c_col [LED_COUNT];

    assign perim = (PERIM_BITS'(i_cfg.width) << 1) + (PERIM_BITS'(i_cfg.height) << 1);

    // The reciprocal has enough fraction bits that the product is the exact quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w    <= i_cfg.width;
            r_h    <= i_cfg.height;
            r_s    <= i_cfg.sample;
            r_prod <= PROD_BITS'(perim) * PROD_BITS'(RECIP);
        end
        if (r_stage[0]) begin
            r_spacing <= r_prod[SHIFT +: PERIM_BITS];
        end
        if (r_stage[1]) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_j[i] <= PERIM_BITS'(i) * r_spacing;
            end
        end
        if (r_stage[2]) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_row_lo[i]  <= c_row[i];
                r_row_end[i] <= c_row[i] + s_s - CW'(1);
                r_col_lo[i]  <= c_col[i];
                r_col_end[i] <= c_col[i] + s_s - CW'(1);
            end
        end
    end

    // Top edge, right edge, bottom edge and left edge, walking clockwise.
    always_comb begin
        w_s      = $signed(CW'(r_w));
        h_s      = $signed(CW'(r_h));
        s_s      = $signed(CW'(r_s));
        right_s  = w_s + h_s;
        bottom_s = w_s + w_s + h_s;
        around_s = bottom_s + h_s;
        for (int i = 0; i < LED_COUNT; i++) begin
            j_s[i] = $signed(CW'(r_j[i]));
            if (j_s[i] <= w_s) begin
                c_row[i] = '0;
                c_col[i] = j_s[i];
            end else if (j_s[i] <= right_s) begin
                c_row[i] = j_s[i] - w_s;
                c_col[i] = w_s - s_s;
            end else if (j_s[i] <= bottom_s) begin
                c_row[i] = h_s - s_s;
                c_col[i] = bottom_s - j_s[i];
            end else begin
                c_row[i] = around_s - j_s[i];
                c_col[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
        end
    end

    assign o_done    = r_stage[3];
    assign o_lat_w   = r_w;
    assign o_lat_h   = r_h;
    assign o_row_lo  = r_row_lo;
    assign o_row_end = r_row_end;
    assign o_col_lo  = r_col_lo;
    assign o_col_end = r_col_end;

endmodule

// ----- rtl/selcs_accum.sv -----
// Pixel engine: input register, raster counters, frame state machine and one averaging
// accumulator per LED window. Depends on selcs_pkg and selcs_pixel_if.
module selcs_accum import selcs_pkg::*; #(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    selcs_pixel_if.sink                                i_pixel,
    output logic                                       o_setup_start,
    input  logic                                       i_setup_done,
    input  logic [DIM_BITS-1:0]                        i_lat_w,
    input  logic [DIM_BITS-1:0]                        i_lat_h,
    input  logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] i_row_lo,
    input  logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] i_row_end,
    input  logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] i_col_lo,
    input  logic [LED_COUNT-1:0][corner_bits(COORD_BITS)-1:0] i_col_end,
    input  logic                                       i_drain_busy,
    output logic                                       o_snap_load,
    output t_rgb [LED_COUNT-1:0]                       o_snap_data
);

    localparam int CW = corner_bits(COORD_BITS);
    localparam int RW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    t_frame_state          r_state;
    t_frame_state          n_state;
    logic                  r_in_valid;
    t_rgb                  r_in_pix;
    logic                  r_in_end;
    logic [DIM_BITS-1:0]   r_col;
    logic [DIM_BITS-1:0]   n_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_row;
    t_rgb [LED_COUNT-1:0]  r_acc;
    t_rgb [LED_COUNT-1:0]  n_acc;
    t_rgb [LED_COUNT-1:0]  upd_acc;

    logic                  consume;
    logic                  in_img;
    logic                  row_wrap;
    logic signed [CW-1:0]  rr;
    logic signed [CW-1:0]  cc;
    logic                  lane_hit [LED_COUNT];

    function automatic t_chan halve_sum(input t_chan a, input t_chan b);
        logic [CHAN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CHAN_BITS:1];
    endfunction

    // Next frame state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_CLOSED: begin
                if (r_in_valid) begin
                    n_state = FS_SETUP;
                end
            end
            FS_SETUP: begin
                if (i_setup_done) begin
                    n_state = FS_OPEN;
                end
            end
            FS_OPEN: begin
                if (consume && r_in_end) begin
                    n_state = FS_CLOSED;
                end
            end
            default: n_state = FS_CLOSED;
        endcase
    end

    // State outputs. A frame-end beat waits while the previous frame's results still drain.
    always_comb begin
        o_setup_start = 1'b0;
        consume       = 1'b0;
        case (r_state)
            FS_CLOSED: o_setup_start = r_in_valid;
            FS_SETUP:  consume       = 1'b0;
            FS_OPEN:   consume       = r_in_valid && !(r_in_end && i_drain_busy);
            default:   consume       = 1'b0;
        endcase
    end

    assign i_pixel.ready = !r_in_valid || consume;
    assign o_snap_load   = consume && r_in_end;
    assign o_snap_data   = upd_acc;

    // Window hits and the running average for every LED in parallel.
    always_comb begin
        rr     = $signed(CW'(r_row));
        cc     = $signed(CW'(r_col));
        in_img = (RW'(r_row) < RW'(i_lat_h)) && (r_col < i_lat_w);
        for (int i = 0; i < LED_COUNT; i++) begin
            lane_hit[i] = in_img
                && (rr >= $signed(i_row_lo[i])) && (rr < $signed(i_row_end[i]))
                && (cc >= $signed(i_col_lo[i])) && (cc < $signed(i_col_end[i]));
            upd_acc[i] = r_acc[i];
            if (lane_hit[i]) begin
                upd_acc[i].red   = halve_sum(r_acc[i].red,   r_in_pix.red);
                upd_acc[i].green = halve_sum(r_acc[i].green, r_in_pix.green);
                upd_acc[i].blue  = halve_sum(r_acc[i].blue,  r_in_pix.blue);
            end
        end
    end

    always_comb begin
        n_acc    = r_acc;
        n_col    = r_col;
        n_row    = r_row;
        row_wrap = ({1'b0, r_col} + (DIM_BITS+1)'(1)) >= {1'b0, i_lat_w};
        if (r_state == FS_SETUP && i_setup_done) begin
            n_acc = '0;
            n_col = '0;
            n_row = '0;
        end else if (consume) begin
            n_acc = upd_acc;
            if (r_in_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_wrap) begin
                n_col = '0;
                if (r_row != '1) begin
                    n_row = r_row + COORD_BITS'(1);
                end
            end else begin
                n_col = r_col + DIM_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_CLOSED;
            r_in_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_pixel.ready) begin
                r_in_valid <= i_pixel.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_pixel.ready && i_pixel.valid) begin
            r_in_pix.red   <= i_pixel.pixel_red;
            r_in_pix.green <= i_pixel.pixel_green;
            r_in_pix.blue  <= i_pixel.pixel_blue;
            r_in_end       <= i_pixel.frame_end;
        end
    end

endmodule

// ----- rtl/selcs_drain.sv -----
// Result drain: holds the frame-end snapshot in a shift line, scales each LED colour by the gain
// and presents one result per beat from an output register. Depends on selcs_pkg, selcs_led_if.
module selcs_drain import selcs_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_snap_load,
    input  t_rgb [LED_COUNT-1:0]  i_snap_data,
    input  logic [GAIN_BITS-1:0]  i_bright,
    output logic                  o_busy,
    selcs_led_if.source           o_led
);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(LED_COUNT - 1);

    t_rgb [LED_COUNT-1:0] r_snap;
    logic                 r_busy;
    logic [IDX_BITS-1:0]  r_idx;
    logic                 r_out_valid;
    t_rgb                 r_out_pix;
    logic [IDX_BITS-1:0]  r_out_idx;
    logic                 r_out_last;

    logic                 advance;
    logic                 at_last;

    assign advance = r_busy && (!r_out_valid || o_led.ready);
    assign at_last = (r_idx == LAST_IDX);
    assign o_busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_snap_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (advance) begin
                r_idx <= r_idx + IDX_BITS'(1);
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_led.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The head of the shift line is always the next LED to go out.
    always_ff @(posedge i_clk) begin
        if (i_snap_load) begin
            r_snap <= i_snap_data;
        end else if (advance) begin
            for (int k = 0; k < LED_COUNT - 1; k++) begin
                r_snap[k] <= r_snap[k+1];
            end
        end
        if (advance) begin
            r_out_pix.red   <= scale_channel(r_snap[0].red,   i_bright);
            r_out_pix.green <= scale_channel(r_snap[0].green, i_bright);
            r_out_pix.blue  <= scale_channel(r_snap[0].blue,  i_bright);
            r_out_idx       <= r_idx;
            r_out_last      <= at_last;
        end
    end

    assign o_led.valid     = r_out_valid;
    assign o_led.led_index = r_out_idx;
    assign o_led.led_red   = r_out_pix.red;
    assign o_led.led_green = r_out_pix.green;
    assign o_led.led_blue  = r_out_pix.blue;
    assign o_led.last_led  = r_out_last;

endmodule

// ----- rtl/screen_edge_led_color_sampler.sv -----
// Screen-edge LED colour sampler, top level. Within a frame one pixel beat is taken per cycle.
// The first pixel of each frame waits while the window placement pipeline runs. An accepted
// frame-end beat loads the snapshot register; results leave through the output register, one
// per cycle while o_led is ready, LED_COUNT in all; a frame-end beat waits while an earlier frame
// still drains. Reset clears the handshake and frame control and loads the register defaults;
// LED accumulators are cleared at the start of every frame. Depends on selcs_pkg and selcs_if.
module screen_edge_led_color_sampler import selcs_pkg::*; #(
    parameter int LED_COUNT  = LED_COUNT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    selcs_pixel_if.sink   i_pixel,
    selcs_led_if.source   o_led,
    selcs_cfg_if.sink     i_cfg
);

    localparam int CW = corner_bits(COORD_BITS);

    t_cfg                          cfg;
    logic                          setup_start;
    logic                          setup_done;
    logic [DIM_BITS-1:0]           lat_w;
    logic [DIM_BITS-1:0]           lat_h;
    logic [LED_COUNT-1:0][CW-1:0]  row_lo;
    logic [LED_COUNT-1:0][CW-1:0]  row_end;
    logic [LED_COUNT-1:0][CW-1:0]  col_lo;
    logic [LED_COUNT-1:0][CW-1:0]  col_end;
    logic                          drain_busy;
    logic                          snap_load;
    t_rgb [LED_COUNT-1:0]          snap_data;

    selcs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    selcs_placer #(
        .LED_COUNT  (LED_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_placer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_start   (setup_start),
        .o_done    (setup_done),
        .o_lat_w   (lat_w),
        .o_lat_h   (lat_h),
        .o_row_lo  (row_lo),
        .o_row_end (row_end),
        .o_col_lo  (col_lo),
        .o_col_end (col_end)
    );

    selcs_accum #(
        .LED_COUNT  (LED_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel       (i_pixel),
        .o_setup_start (setup_start),
        .i_setup_done  (setup_done),
        .i_lat_w       (lat_w),
        .i_lat_h       (lat_h),
        .i_row_lo      (row_lo),
        .i_row_end     (row_end),
        .i_col_lo      (col_lo),
        .i_col_end     (col_end),
        .i_drain_busy  (drain_busy),
        .o_snap_load   (snap_load),
        .o_snap_data   (snap_data)
    );

    selcs_drain #(
        .LED_COUNT (LED_COUNT)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_load (snap_load),
        .i_snap_data (snap_data),
        .i_bright    (cfg.bright),
        .o_busy      (drain_busy),
        .o_led       (o_led)
    );

endmodule
